>>> sv/gso_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Gram-Schmidt orthonormalizing store.
// Used by gso_shsub and gram_schmidt_orthonormalize; no dependencies.
package gso_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;

  // Configuration reset values
  localparam logic [4:0]  NUM_ROWS_RST  = 5'd16;
  localparam logic [4:0]  NUM_COLS_RST  = 5'd16;
  localparam logic [4:0]  NUM_CONST_RST = 5'd0;
  localparam logic [3:0]  MAX_ITER_RST  = 4'd1;
  localparam logic [30:0] THRESH_RST    = 31'd0;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    CFG_NUM_ROWS  = 3'd0,
    CFG_NUM_COLS  = 3'd1,
    CFG_NUM_CONST = 3'd2,
    CFG_MAX_ITER  = 3'd3,
    CFG_THRESH    = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    UOP_SQRT = 1'b0,
    UOP_DIV  = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [4:0]         vector_count;
  } out_item_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] result;
  } unit_rsp_t;

endpackage

>>> sv/gso_shsub.sv
`timescale 1ns / 1ps
// Shared shift/subtract unit: 64-bit integer square root (one root bit per cycle)
// and 48/32-bit restoring divide (one quotient bit per cycle). Uses gso_pkg.
module gso_shsub (
  input  logic               clk,
  input  logic               rst,
  input  gso_pkg::unit_req_t req,
  input  logic [63:0]        radicand,
  input  logic [47:0]        numer,
  input  logic [31:0]        denom,
  output gso_pkg::unit_rsp_t rsp
);

  localparam int UW = 36;
  localparam logic [5:0] SQRT_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS  = 6'd48;

  logic              busy;
  gso_pkg::unit_op_t op;
  logic [UW-1:0]     rem;
  logic [63:0]       src;
  logic [47:0]       quo;
  logic [31:0]       den;
  logic [5:0]        cnt;
  logic              done;

  logic [UW-1:0] opa;
  logic [UW-1:0] opb;
  logic [UW:0]   diff;
  logic          take;

  always_comb begin
    if (op == gso_pkg::UOP_SQRT) begin
      opa = {rem[UW-3:0], src[63:62]};
      opb = {quo[UW-3:0], 2'b01};
    end else begin
      opa = {rem[UW-2:0], src[63]};
      opb = UW'(den);
    end
    diff = {1'b0, opa} - {1'b0, opb};
    take = !diff[UW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= gso_pkg::UOP_SQRT;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        rem  <= '0;
        quo  <= '0;
        den  <= denom;
        if (req.op == gso_pkg::UOP_SQRT) begin
          src <= radicand;
          cnt <= SQRT_STEPS - 6'd1;
        end else begin
          src <= {numer, 16'd0};
          cnt <= DIV_STEPS - 6'd1;
        end
      end else if (busy) begin
        rem <= take ? diff[UW-1:0] : opa;
        quo <= {quo[46:0], take};
        src <= (op == gso_pkg::UOP_SQRT) ? {src[61:0], 2'b00} : {src[62:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = quo;

endmodule

>>> sv/gram_schmidt_orthonormalize.sv
`timescale 1ns / 1ps
// Orthonormalizing column store, modified Gram-Schmidt in Q16.16. Uses gso_pkg, gso_shsub.
// Write and no-op: result in the cycle after acceptance, one per cycle while not stalled.
// Read: result via ST_READ. Run: columns from num_const on are projected against
//   the earlier ones, normed and, if above thresh, scaled and moved, with the shared
//   multiplier and bit-serial sqrt/divide unit. Not ready while a read or run is in work.
// Synchronous reset clears control, configuration and the count; the store is not cleared.
module gram_schmidt_orthonormalize #(
  parameter int MAX_ROWS = gso_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gso_pkg::MAX_COLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  gso_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gso_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int CIW   = $clog2(MAX_COLS);

  typedef enum logic [23:0] {
    ST_IDLE     = 24'b1 << 0,
    ST_READ     = 24'b1 << 1,
    ST_COL      = 24'b1 << 2,
    ST_DOT_RD   = 24'b1 << 3,
    ST_DOT_MUL  = 24'b1 << 4,
    ST_DOT_ACC  = 24'b1 << 5,
    ST_FACT     = 24'b1 << 6,
    ST_UPD_RD   = 24'b1 << 7,
    ST_UPD_MUL  = 24'b1 << 8,
    ST_UPD_WR   = 24'b1 << 9,
    ST_NRM_RD   = 24'b1 << 10,
    ST_NRM_MUL  = 24'b1 << 11,
    ST_NRM_ACC  = 24'b1 << 12,
    ST_SQRT     = 24'b1 << 13,
    ST_SQRT_WT  = 24'b1 << 14,
    ST_CHK      = 24'b1 << 15,
    ST_SCL_RD   = 24'b1 << 16,
    ST_SCL_DIV  = 24'b1 << 17,
    ST_SCL_WT   = 24'b1 << 18,
    ST_CPY_RD   = 24'b1 << 19,
    ST_CPY_WR   = 24'b1 << 20,
    ST_ACPT     = 24'b1 << 21,
    ST_NEXT     = 24'b1 << 22,
    ST_DONE     = 24'b1 << 23
  } state_t;

  function automatic logic [AW-1:0] maddr(input logic [8:0] rr, input logic [8:0] cc);
    logic [16:0] t;
    t = 17'(rr) * 17'(MAX_COLS) + 17'(cc);
    return t[AW-1:0];
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  // Q32.32 to Q16.16, round half up, with the input clamped to +-2^48
  function automatic logic signed [33:0] round_q(input logic signed [63:0] a);
    logic signed [63:0] c;
    logic signed [63:0] t;
    c = a;
    if (a > 64'sd281474976710656) c = 64'sd281474976710656;
    if (a < -64'sd281474976710656) c = -64'sd281474976710656;
    t = c + 64'sd32768;
    return t[49:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
    if (x > 35'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -35'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // configuration
  logic [4:0]  num_rows;
  logic [4:0]  num_cols;
  logic [4:0]  num_const;
  logic [3:0]  max_iter;
  logic [30:0] thresh;

  state_t state;
  logic [RIW-1:0] r;
  logic [RIW-1:0] rows_last;
  logic [CIW-1:0] i;
  logic [CIW-1:0] j;
  logic [CIW-1:0] cur;
  logic [CIW-1:0] cols_last;
  logic [3:0]     it;
  logic [3:0]     iters_last;
  logic [4:0]     count;
  logic [4:0]     accepted_count;
  logic           rd_inside;

  logic signed [63:0] acc;
  logic signed [31:0] fact;
  logic signed [63:0] prod;
  logic [63:0]        ss;
  logic [31:0]        nrm;

  // store
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] qa;
  logic signed [31:0] qb;
  logic               re;
  logic [AW-1:0]      ra_a;
  logic [AW-1:0]      ra_b;
  logic               we;
  logic [AW-1:0]      wa;
  logic signed [31:0] wd;

  gso_pkg::unit_req_t ureq;
  gso_pkg::unit_rsp_t ursp;

  logic        acc_in;
  logic        ext_inside;
  logic [8:0]  rows_eff;
  logic [8:0]  cols_eff;
  logic        r_last;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [33:0] proj;
  logic signed [34:0] upd;
  logic [64:0] ss_sum;
  logic [31:0] mag;
  logic [47:0] numer;
  logic signed [31:0] scaled;

  assign acc_in     = in_valid && !in_stall;
  assign in_stall   = (state != ST_IDLE) || (out_valid && out_stall);
  assign cfg_ready  = 1'b1;
  assign ext_inside = (9'(in_data.row_index) < 9'(MAX_ROWS)) &&
                      (9'(in_data.col_index) < 9'(MAX_COLS));
  assign rows_eff   = (9'(num_rows) > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : 9'(num_rows);
  assign cols_eff   = (9'(num_cols) > 9'(MAX_COLS)) ? 9'(MAX_COLS) : 9'(num_cols);
  assign r_last     = (r == rows_last);

  always_comb begin
    mul_a = qa;
    mul_b = qb;
    if (state == ST_UPD_MUL) mul_a = fact;
    if (state == ST_NRM_MUL) mul_b = qa;
  end

  assign proj   = round_q(prod);
  assign upd    = {{3{qa[31]}}, qa} - {proj[33], proj};
  assign ss_sum = {1'b0, ss} + {1'b0, prod};
  assign mag    = qa[31] ? 32'(-qa) : 32'(qa);
  assign numer  = {mag, 16'd0} + 48'(nrm[31:1]);

  // quotient of 2^31 or more (32768.0 in Q16.16) saturates to the 32-bit limit of its sign
  always_comb begin
    if (|ursp.result[47:31]) scaled = qa[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else if (qa[31]) scaled = -$signed({1'b0, ursp.result[30:0]});
    else scaled = $signed({1'b0, ursp.result[30:0]});
  end

  // store ports
  always_comb begin
    re   = 1'b0;
    ra_a = maddr(9'(r), 9'(i));
    ra_b = maddr(9'(r), 9'(j));
    we   = 1'b0;
    wa   = maddr(9'(r), 9'(i));
    wd   = sat32(upd);
    case (state)
      ST_IDLE: begin
        ra_a = maddr(9'(in_data.row_index), 9'(in_data.col_index));
        wa   = ra_a;
        wd   = in_data.elem_value;
        re   = acc_in && (in_data.func == gso_pkg::FUNC_READ);
        we   = acc_in && (in_data.func == gso_pkg::FUNC_WRITE) && ext_inside;
      end
      ST_DOT_RD, ST_UPD_RD, ST_NRM_RD, ST_SCL_RD, ST_CPY_RD: re = 1'b1;
      ST_UPD_WR: we = 1'b1;
      ST_SCL_WT: begin
        we = ursp.done;
        wd = scaled;
      end
      ST_CPY_WR: begin
        we = 1'b1;
        wa = maddr(9'(r), 9'(cur));
        wd = qa;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) begin
      qa <= mem[ra_a];
      qb <= mem[ra_b];
    end
  end

  assign ureq.start = (state == ST_SQRT) || (state == ST_SCL_DIV);
  assign ureq.op    = (state == ST_SQRT) ? gso_pkg::UOP_SQRT : gso_pkg::UOP_DIV;

  gso_shsub u_shsub (
    .clk      (clk),
    .rst      (rst),
    .req      (ureq),
    .radicand (ss),
    .numer    (numer),
    .denom    (nrm),
    .rsp      (ursp)
  );

  always_ff @(posedge clk) begin
    if (state == ST_DOT_MUL || state == ST_UPD_MUL || state == ST_NRM_MUL) begin
      prod <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows  <= gso_pkg::NUM_ROWS_RST;
      num_cols  <= gso_pkg::NUM_COLS_RST;
      num_const <= gso_pkg::NUM_CONST_RST;
      max_iter  <= gso_pkg::MAX_ITER_RST;
      thresh    <= gso_pkg::THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gso_pkg::CFG_NUM_ROWS:  num_rows  <= cfg_data[4:0];
        gso_pkg::CFG_NUM_COLS:  num_cols  <= cfg_data[4:0];
        gso_pkg::CFG_NUM_CONST: num_const <= cfg_data[4:0];
        gso_pkg::CFG_MAX_ITER:  max_iter  <= cfg_data[3:0];
        gso_pkg::CFG_THRESH:    thresh    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      accepted_count <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (acc_in) begin
            case (in_data.func)
              gso_pkg::FUNC_READ: begin
                rd_inside <= ext_inside;
                state     <= ST_READ;
              end
              gso_pkg::FUNC_RUN: begin
                if (9'(num_const) >= cols_eff || rows_eff == 9'd0) begin
                  accepted_count        <= '0;
                  out_valid             <= 1'b1;
                  out_data.read_value   <= '0;
                  out_data.vector_count <= '0;
                end else begin
                  i          <= CIW'(num_const);
                  cur        <= CIW'(num_const);
                  count      <= '0;
                  rows_last  <= RIW'(rows_eff - 9'd1);
                  cols_last  <= CIW'(cols_eff - 9'd1);
                  iters_last <= (max_iter == 4'd0) ? 4'd0 : max_iter - 4'd1;
                  state      <= ST_COL;
                end
              end
              default: begin
                out_valid             <= 1'b1;
                out_data.read_value   <= '0;
                out_data.vector_count <= accepted_count;
              end
            endcase
          end
        end
        ST_READ: begin
          out_valid             <= 1'b1;
          out_data.read_value   <= rd_inside ? qa : 32'sd0;
          out_data.vector_count <= accepted_count;
          state                 <= ST_IDLE;
        end
        ST_COL: begin
          acc   <= '0;
          ss    <= '0;
          j     <= '0;
          it    <= '0;
          r     <= '0;
          state <= (cur == '0) ? ST_NRM_RD : ST_DOT_RD;
        end
        ST_DOT_RD:  state <= ST_DOT_MUL;
        ST_DOT_MUL: state <= ST_DOT_ACC;
        ST_DOT_ACC: begin
          acc <= sat_add64(acc, prod);
          if (r_last) begin
            r     <= '0;
            state <= ST_FACT;
          end else begin
            r     <= r + 1'b1;
            state <= ST_DOT_RD;
          end
        end
        ST_FACT: begin
          fact  <= sat32(35'(round_q(acc)));
          state <= ST_UPD_RD;
        end
        ST_UPD_RD:  state <= ST_UPD_MUL;
        ST_UPD_MUL: state <= ST_UPD_WR;
        ST_UPD_WR: begin
          if (r_last) begin
            r   <= '0;
            acc <= '0;
            if (j == cur - 1'b1) begin
              j <= '0;
              if (it == iters_last) begin
                ss    <= '0;
                state <= ST_NRM_RD;
              end else begin
                it    <= it + 4'd1;
                state <= ST_DOT_RD;
              end
            end else begin
              j     <= j + 1'b1;
              state <= ST_DOT_RD;
            end
          end else begin
            r     <= r + 1'b1;
            state <= ST_UPD_RD;
          end
        end
        ST_NRM_RD:  state <= ST_NRM_MUL;
        ST_NRM_MUL: state <= ST_NRM_ACC;
        ST_NRM_ACC: begin
          ss <= ss_sum[64] ? {64{1'b1}} : ss_sum[63:0];
          if (r_last) begin
            r     <= '0;
            state <= ST_SQRT;
          end else begin
            r     <= r + 1'b1;
            state <= ST_NRM_RD;
          end
        end
        ST_SQRT: state <= ST_SQRT_WT;
        ST_SQRT_WT: begin
          if (ursp.done) begin
            nrm   <= ursp.result[31:0];
            state <= ST_CHK;
          end
        end
        ST_CHK: state <= ({1'b0, nrm} > {2'b00, thresh}) ? ST_SCL_RD : ST_NEXT;
        ST_SCL_RD:  state <= ST_SCL_DIV;
        ST_SCL_DIV: state <= ST_SCL_WT;
        ST_SCL_WT: begin
          if (ursp.done) begin
            if (r_last) begin
              r     <= '0;
              state <= (cur != i) ? ST_CPY_RD : ST_ACPT;
            end else begin
              r     <= r + 1'b1;
              state <= ST_SCL_RD;
            end
          end
        end
        ST_CPY_RD: state <= ST_CPY_WR;
        ST_CPY_WR: begin
          if (r_last) begin
            r     <= '0;
            state <= ST_ACPT;
          end else begin
            r     <= r + 1'b1;
            state <= ST_CPY_RD;
          end
        end
        ST_ACPT: begin
          cur   <= cur + 1'b1;
          count <= count + 5'd1;
          state <= ST_NEXT;
        end
        ST_NEXT: begin
          if (i == cols_last) begin
            state <= ST_DONE;
          end else begin
            i     <= i + 1'b1;
            state <= ST_COL;
          end
        end
        ST_DONE: begin
          accepted_count        <= count;
          out_valid             <= 1'b1;
          out_data.read_value   <= '0;
          out_data.vector_count <= count;
          state                 <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
